@@ design/sha256md_pkg.sv @@
// shared types and constants of the sha-256 message digest block
// round constants, initial hash values, datapath command struct
// no dependencies
`default_nettype none

package sha256md_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 64;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned WIN_WORDS = 16;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t sel;
    logic [2:0] len_idx;
    logic      count_inc;
    logic      init_work;
    logic      round_en;
    logic [5:0] round;
    logic      hash_add;
    logic      hash_init;
    logic [2:0] word_sel;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ design/sha256_message_digest.sv @@
// SHA-256 digest over a byte stream, one byte per input beat. The beat that
// completes a 64-byte block is followed by the busy states S_COMP and S_ADD
// (64 rounds, one per cycle through the single round unit, and the hash
// update). An end beat pads one byte per cycle up to the block tail, adds
// eight length bytes and one or two further compressions, then presents the
// eight digest words as eight output beats, word 0 first; no input is taken
// until the last digest beat has gone. Top level of sha256md_ctrl and sha256md_dp.
`default_nettype none

module sha256_message_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // has_byte
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic             out_tlast   // last_word
);

  sha256md_pkg::dp_cmd_t cmd;
  logic [31:0]           digest_word;
  logic [2:0]            word_index;

  sha256md_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .has_byte       (in_tuser),
    .end_of_message (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .word_index     (word_index),
    .last_word      (out_tlast),
    .cmd            (cmd)
  );

  sha256md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, word_index, digest_word};

endmodule

`default_nettype wire

@@ design/sha256md_dp.sv @@
// datapath of the sha-256 block: byte window, schedule, round unit, hash words
// driven by the command struct from sha256md_ctrl
// depends on sha256md_pkg
`default_nettype none

module sha256md_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha256md_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]           data_byte,
  output logic [31:0]               digest_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  logic [31:0] win_r   [sha256md_pkg::WIN_WORDS];
  logic [31:0] hash_r  [sha256md_pkg::HASH_WORDS];
  logic [31:0] var_r   [sha256md_pkg::HASH_WORDS];
  logic [60:0] count_r;

  logic [63:0] bit_len;
  logic [7:0]  shift_byte;
  logic [31:0] s0_sched, s1_sched, w_new;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  assign bit_len = {count_r, 3'b000};

  always_comb begin
    case (cmd.sel)
      sha256md_pkg::SEL_DATA: shift_byte = data_byte;
      sha256md_pkg::SEL_PAD:  shift_byte = sha256md_pkg::PAD_BYTE;
      sha256md_pkg::SEL_ZERO: shift_byte = 8'h00;
      sha256md_pkg::SEL_LEN:  shift_byte = bit_len[63 - 8 * int'(cmd.len_idx) -: 8];
      default:                shift_byte = 8'h00;
    endcase
  end

  always_comb begin
    s0_sched = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1_sched = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new    = win_r[0] + s0_sched + win_r[9] + s1_sched;
    big_s1   = rotr(var_r[4], 6) ^ rotr(var_r[4], 11) ^ rotr(var_r[4], 25);
    ch       = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    t1       = var_r[7] + big_s1 + ch + sha256md_pkg::ROUND_K[cmd.round] + win_r[0];
    big_s0   = rotr(var_r[0], 2) ^ rotr(var_r[0], 13) ^ rotr(var_r[0], 22);
    maj      = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t2       = big_s0 + maj;
  end

  // window: bytes shift in at the top (low byte of word 15), rounds shift words down
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[15] <= {win_r[15][23:0], shift_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_work) begin
      for (int i = 0; i < 8; i++) begin
        var_r[i] <= hash_r[i];
      end
    end else if (cmd.round_en) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha256md_pkg::INIT_HASH[i];
      end
      count_r <= '0;
    end else begin
      if (cmd.hash_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + var_r[i];
        end
      end
      if (cmd.count_inc) begin
        count_r <= count_r + 61'd1;
      end
    end
  end

  assign digest_word = hash_r[cmd.word_sel];

endmodule

`default_nettype wire

@@ design/sha256md_ctrl.sv @@
// controller of the sha-256 block: byte intake, padding, rounds, digest beats
// issues the command struct to sha256md_dp
// depends on sha256md_pkg
`default_nettype none

module sha256md_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic                  has_byte,
  input  wire logic                  end_of_message,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2:0]                 word_index,
  output logic                       last_word,
  output sha256md_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_ADD,
    S_PAD,
    S_LEN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_OUT
  } ret_t;

  state_t     state_r, state_nxt;
  ret_t       ret_r, ret_nxt;
  logic [5:0] round_r, round_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [2:0] len_r, len_nxt;
  logic [2:0] word_r, word_nxt;
  logic       mark_r, mark_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign word_index = word_r;
  assign last_word  = (word_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = round_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    word_nxt  = word_r;
    mark_nxt  = mark_r;
    cmd          = '0;
    cmd.sel      = sha256md_pkg::SEL_DATA;
    cmd.round    = round_r;
    cmd.len_idx  = len_r;
    cmd.word_sel = word_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mark_nxt = 1'b0;
          if (has_byte) begin
            cmd.shift_en  = 1'b1;
            cmd.count_inc = 1'b1;
            pos_nxt       = pos_r + 6'd1;
            if (pos_r == 6'd63) begin
              cmd.init_work = 1'b1;
              state_nxt     = S_COMP;
              round_nxt     = '0;
              ret_nxt       = end_of_message ? RET_PAD : RET_IDLE;
            end else if (end_of_message) begin
              state_nxt = S_PAD;
            end
          end else if (end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.hash_add = 1'b1;
        case (ret_r)
          RET_PAD: state_nxt = S_PAD;
          RET_OUT: begin
            state_nxt = S_OUT;
            word_nxt  = '0;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.sel      = mark_r ? sha256md_pkg::SEL_ZERO : sha256md_pkg::SEL_PAD;
        mark_nxt     = 1'b1;
        pos_nxt      = pos_r + 6'd1;
        if (pos_r == 6'd55) begin
          state_nxt = S_LEN;
          len_nxt   = '0;
        end else if (pos_r == 6'd63) begin
          cmd.init_work = 1'b1;
          state_nxt     = S_COMP;
          round_nxt     = '0;
          ret_nxt       = RET_PAD;
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.sel      = sha256md_pkg::SEL_LEN;
        pos_nxt      = pos_r + 6'd1;
        len_nxt      = len_r + 3'd1;
        if (len_r == 3'd7) begin
          cmd.init_work = 1'b1;
          state_nxt     = S_COMP;
          round_nxt     = '0;
          ret_nxt       = RET_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (word_r == 3'd7) begin
            cmd.hash_init = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            word_nxt = word_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RET_IDLE;
      round_r <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      word_r  <= '0;
      mark_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      word_r  <= word_nxt;
      mark_r  <= mark_nxt;
    end
  end

  // length bytes always land in the last eight positions of a block
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEN |-> pos_r[5:3] == 3'd7)
    else $error("length byte outside block tail");

  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && round_r != 6'd63)
      |=> (state_r == S_COMP && round_r == $past(round_r) + 6'd1))
    else $error("round counter broke sequence");

  a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_work |=> (state_r == S_COMP && round_r == 6'd0 && pos_r == 6'd0))
    else $error("compression started off a block boundary");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && last_word) |=> (in_tready && pos_r == 6'd0))
    else $error("block not idle after final digest beat");

endmodule

`default_nettype wire
